FILE: hdl/fdnr_pkg.sv
// Shared widths, defaults and width helpers for the feedback delay network reverb core.
package fdnr_pkg;

    // Fixed field widths
    localparam int SAMPLE_W  = 16;   // Q1.15 samples and gain
    localparam int DELAY_W   = 20;   // Q12.8 delays
    localparam int OUT_W     = 18;   // Q3.15 output sum
    localparam int NUM_REGS  = 4;    // spread factor registers
    localparam int CFG_IDX_W = 2;

    // Parameter defaults
    localparam int DEF_NUM_LINES = 4;
    localparam int DEF_LINE_LEN  = 4096;

    // Width of the tap sum for n lines
    function automatic int sum_width(input int n);
        return SAMPLE_W + $clog2(n);
    endfunction

    // Width of the Householder feedback term for n lines
    function automatic int fb_width(input int n);
        return SAMPLE_W + sum_width(n) + 1 - 14;
    endfunction

endpackage

FILE: hdl/feedback_delay_network_reverb_core.sv
// Top level of the feedback delay network reverb core.
//
// Input channel (i_in_valid / o_in_ready) takes one request per audio sample:
// sample, base delay, delay spread and feedback gain. Output channel
// (o_out_valid / i_out_ready) returns one sample_out per request, in order.
// Spread factors are written through i_cfg_we / i_cfg_index / i_cfg_data.
//
// Each request walks the lines one at a time over the single read port:
// spread multiply, tap address and read a, read b, interpolate, tap sum,
// then feedback scaling (S_FB1 to S_FB3) and one write per line in S_WR.
// A new request is accepted only in S_IDLE, after the previous one has left
// S_OUT; o_out_valid rises once S_OUT loads the output register.
// The output register lets a new request in while a result waits; a request
// that finishes while the previous result is still held waits in its last
// state until the receiver takes it.
// Reset clears the write pointer, spread factors and handshake state. The
// line memory is not swept: entries not yet written since reset read as zero,
// tracked by the write pointer and a wrap flag, so no clearing pass is needed.
module feedback_delay_network_reverb_core #(
    parameter int NUM_LINES = fdnr_pkg::DEF_NUM_LINES,
    parameter int LINE_LEN  = fdnr_pkg::DEF_LINE_LEN
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input requests
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [fdnr_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic [fdnr_pkg::DELAY_W-1:0]         i_base_delay,
    input  logic signed [fdnr_pkg::DELAY_W-1:0]  i_delay_spread,
    input  logic signed [fdnr_pkg::SAMPLE_W-1:0] i_feedback_gain,
    // output requests
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [fdnr_pkg::OUT_W-1:0]    o_sample_out,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [fdnr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fdnr_pkg::SAMPLE_W-1:0]        i_cfg_data
);
    import fdnr_pkg::*;

    localparam int SUM_W  = sum_width(NUM_LINES);
    localparam int FB_W   = fb_width(NUM_LINES);
    localparam int WW     = FB_W + 2;
    localparam int PTR_W  = $clog2(LINE_LEN);
    localparam int ADDR_W = $clog2(NUM_LINES * LINE_LEN);
    localparam int LW     = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int DW     = 26;
    localparam int PRW    = DELAY_W + SAMPLE_W;
    localparam int IPW    = 26;

    localparam logic signed [DW-1:0] D_MIN = DW'(256);
    localparam logic signed [DW-1:0] D_MAX = DW'((LINE_LEN - 2) * 256);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_MUL  = 11'b000_0000_0010,
        S_ADDR = 11'b000_0000_0100,
        S_RDB  = 11'b000_0000_1000,
        S_INTP = 11'b000_0001_0000,
        S_TAP  = 11'b000_0010_0000,
        S_FB1  = 11'b000_0100_0000,
        S_FB2  = 11'b000_1000_0000,
        S_FB3  = 11'b001_0000_0000,
        S_WR   = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Request fields
    logic signed [SAMPLE_W-1:0] r_x;
    logic [DELAY_W-1:0]         r_base;
    logic signed [DELAY_W-1:0]  r_spread;
    logic signed [SAMPLE_W-1:0] r_gain;

    // Configuration
    logic signed [SAMPLE_W-1:0] r_factor [NUM_REGS];

    // Line walk
    logic [LW-1:0]              r_line;
    logic signed [PRW-1:0]      r_prod;
    logic [7:0]                 r_frac;
    logic [PTR_W-1:0]           r_ti;
    logic signed [SAMPLE_W-1:0] r_a;
    logic signed [IPW-1:0]      r_iprod;
    logic signed [SAMPLE_W-1:0] r_tap [NUM_LINES];
    logic signed [SUM_W-1:0]    r_sum;

    // Shared write pointer; wrap flag marks every entry as written
    logic [PTR_W-1:0]           r_ptr;
    logic                       r_wrapped;

    // Line memory
    logic [SAMPLE_W-1:0]        r_mem [NUM_LINES * LINE_LEN];
    logic [SAMPLE_W-1:0]        r_rdata;
    logic                       r_rd_ok;

    // Output register
    logic                       r_out_valid;
    logic signed [OUT_W-1:0]    r_out;

    logic signed [FB_W-1:0]     fb;

    logic                       in_acc;
    logic                       last_line;
    logic                       out_free;
    logic [LW+1:0]              line_x;
    logic signed [SAMPLE_W-1:0] factor_c;
    logic signed [DW-1:0]       sp_q_c;
    logic signed [DW-1:0]       d_c;
    logic [DW-1:0]              dc_c;
    logic [PTR_W:0]             tn_c;
    logic [7:0]                 frac_c;
    logic [PTR_W:0]             diff_c;
    logic [PTR_W:0]             tiw_c;
    logic [PTR_W-1:0]           ti_c;
    logic [PTR_W-1:0]           ti1_c;
    logic [PTR_W-1:0]           rd_idx;
    logic [ADDR_W-1:0]          rd_addr;
    logic [ADDR_W-1:0]          wr_addr;
    logic signed [SAMPLE_W-1:0] rd_val;
    logic signed [SAMPLE_W:0]   dab_c;
    logic signed [17:0]         tap_w_c;
    logic signed [SAMPLE_W-1:0] tap_c;
    logic signed [31:0]         gt_c;
    logic signed [31:0]         gts_c;
    logic signed [WW-1:0]       w_c;
    logic [SAMPLE_W-1:0]        w_sat;
    logic signed [19:0]         sum_x;
    logic signed [OUT_W-1:0]    sum_sat;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign last_line  = (r_line == LW'(NUM_LINES - 1));
    assign out_free   = !r_out_valid || i_out_ready;

    // Spread factor of the current line; lines past the registers use zero
    assign line_x   = (LW+2)'(r_line);
    assign factor_c = (line_x < NUM_REGS) ? r_factor[line_x[1:0]] : '0;

    // Tap delay, clamp, integer and fractional parts, tap index
    always_comb begin
        sp_q_c = DW'(r_prod >>> 12);
        d_c    = $signed({{(DW-DELAY_W){1'b0}}, r_base}) + sp_q_c;
        if (d_c < D_MIN) begin
            dc_c = D_MIN;
        end else if (d_c > D_MAX) begin
            dc_c = D_MAX;
        end else begin
            dc_c = d_c;
        end
        tn_c   = (PTR_W+1)'(dc_c >> 8) + (PTR_W+1)'(dc_c[7:0] != 8'd0);
        frac_c = 8'(~dc_c[7:0] + 8'd1);
        diff_c = {1'b0, r_ptr} - tn_c;
        tiw_c  = diff_c[PTR_W] ? diff_c + (PTR_W+1)'(LINE_LEN) : diff_c;
        ti_c   = PTR_W'(tiw_c);
        ti1_c  = (r_ti == PTR_W'(LINE_LEN - 1)) ? '0 : r_ti + PTR_W'(1);
    end

    // Memory addressing: read a in S_ADDR, read b in S_RDB, write at the pointer
    assign rd_idx  = (r_state == S_ADDR) ? ti_c : ti1_c;
    assign rd_addr = ADDR_W'(r_line) * ADDR_W'(LINE_LEN) + ADDR_W'(rd_idx);
    assign wr_addr = ADDR_W'(r_line) * ADDR_W'(LINE_LEN) + ADDR_W'(r_ptr);
    assign rd_val  = r_rd_ok ? $signed(r_rdata) : '0;

    // Interpolation
    assign dab_c   = (SAMPLE_W+1)'(rd_val) - (SAMPLE_W+1)'(r_a);
    assign tap_w_c = 18'(r_a) + 18'(r_iprod >>> 8);
    assign tap_c   = SAMPLE_W'(tap_w_c);

    // Written value: x + g*tap/2^15 + feedback, saturated
    always_comb begin
        gt_c  = 32'(r_gain) * 32'(r_tap[r_line]);
        gts_c = gt_c >>> 15;
        w_c   = WW'(r_x) + WW'(gts_c) + WW'(fb);
        if (w_c > WW'(32767)) begin
            w_sat = 16'h7FFF;
        end else if (w_c < -WW'(32768)) begin
            w_sat = 16'h8000;
        end else begin
            w_sat = SAMPLE_W'(w_c);
        end
    end

    // Output saturation
    always_comb begin
        sum_x = 20'(r_sum);
        if (sum_x > 20'sd131071) begin
            sum_sat = 18'sh1FFFF;
        end else if (sum_x < -20'sd131072) begin
            sum_sat = 18'sh20000;
        end else begin
            sum_sat = OUT_W'(sum_x);
        end
    end

    // Feedback scaling unit
    fdnr_fb_unit #(
        .NUM_LINES (NUM_LINES)
    ) u_fb (
        .i_clk  (i_clk),
        .i_gain (r_gain),
        .i_sum  (r_sum),
        .o_fb   (fb)
    );

    // Line memory: one read and one write port, registered read data
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            r_mem[wr_addr] <= w_sat;
        end
        r_rdata <= r_mem[rd_addr];
        r_rd_ok <= r_wrapped || (rd_idx < r_ptr);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_factor[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_factor[i_cfg_index] <= $signed(i_cfg_data);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_MUL;
            S_MUL:  n_state = S_ADDR;
            S_ADDR: n_state = S_RDB;
            S_RDB:  n_state = S_INTP;
            S_INTP: n_state = S_TAP;
            S_TAP:  n_state = last_line ? S_FB1 : S_MUL;
            S_FB1:  n_state = S_FB2;
            S_FB2:  n_state = S_FB3;
            S_FB3:  n_state = S_WR;
            S_WR:   n_state = last_line ? S_OUT : S_WR;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_line      <= '0;
            r_ptr       <= '0;
            r_wrapped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc || (r_state == S_FB3)) begin
                r_line <= '0;
            end else if ((r_state == S_TAP || r_state == S_WR) && !last_line) begin
                r_line <= r_line + LW'(1);
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
                if (r_ptr == PTR_W'(LINE_LEN - 1)) begin
                    r_ptr     <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_ptr <= r_ptr + PTR_W'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x      <= i_sample_in;
            r_base   <= i_base_delay;
            r_spread <= i_delay_spread;
            r_gain   <= i_feedback_gain;
            r_sum    <= '0;
        end
        if (r_state == S_MUL) begin
            r_prod <= PRW'(r_spread) * PRW'(factor_c);
        end
        if (r_state == S_ADDR) begin
            r_frac <= frac_c;
            r_ti   <= ti_c;
        end
        if (r_state == S_RDB) begin
            r_a <= rd_val;
        end
        if (r_state == S_INTP) begin
            r_iprod <= IPW'($signed({1'b0, r_frac})) * IPW'(dab_c);
        end
        if (r_state == S_TAP) begin
            r_tap[r_line] <= tap_c;
            r_sum         <= r_sum + SUM_W'(tap_c);
        end
        if (r_state == S_OUT && out_free) begin
            r_out <= sum_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

endmodule

FILE: hdl/fdnr_fb_unit.sv
// Householder feedback term floor(-2*g*sum / (N*2^15)), three register stages.
module fdnr_fb_unit #(
    parameter int NUM_LINES = fdnr_pkg::DEF_NUM_LINES
) (
    input  logic                                              i_clk,
    input  logic signed [fdnr_pkg::SAMPLE_W-1:0]              i_gain,
    input  logic signed [fdnr_pkg::sum_width(NUM_LINES)-1:0]  i_sum,
    output logic signed [fdnr_pkg::fb_width(NUM_LINES)-1:0]   o_fb
);
    import fdnr_pkg::*;

    localparam int SUM_W = sum_width(NUM_LINES);
    localparam int PW    = SAMPLE_W + SUM_W;
    localparam int TW    = fb_width(NUM_LINES);
    localparam int LG    = $clog2(NUM_LINES);
    localparam int K     = TW + LG;
    localparam int MW    = K + 1;
    localparam int UQW   = TW + MW;
    // Reciprocal of NUM_LINES, rounded up; exact for inputs below 2^TW
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << K) + NUM_LINES - 1) / NUM_LINES);

    logic signed [PW-1:0]  r_prod;
    logic [UQW-1:0]        r_uq;
    logic                  r_neg;

    logic signed [PW:0]    v_c;
    logic signed [PW:0]    vs_c;
    logic signed [TW-1:0]  t_c;
    logic [TW-1:0]         mag_c;
    logic [TW-1:0]         u_c;
    logic [TW-1:0]         q_c;

    // Stage 1: g * sum
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_gain) * PW'(i_sum);
    end

    // Stage 2: floor(-prod / 2^14), then magnitude times reciprocal
    always_comb begin
        v_c   = -((PW+1)'(r_prod));
        vs_c  = v_c >>> 14;
        t_c   = TW'(vs_c);
        mag_c = t_c[TW-1] ? TW'(-t_c) : TW'(t_c);
        // floor of a negative quotient rounds the magnitude up
        u_c   = t_c[TW-1] ? mag_c + TW'(NUM_LINES - 1) : mag_c;
    end

    always_ff @(posedge i_clk) begin
        r_uq  <= UQW'(u_c) * UQW'(RECIP);
        r_neg <= t_c[TW-1];
    end

    // Stage 3: restore sign
    assign q_c = TW'(r_uq >> K);

    always_ff @(posedge i_clk) begin
        o_fb <= r_neg ? -$signed(q_c) : $signed(q_c);
    end

endmodule

FILE: tb/feedback_delay_network_reverb_core_tb.sv
// Self-checking testbench for the feedback delay network reverb core.
module feedback_delay_network_reverb_core_tb;

    import fdnr_pkg::*;

    localparam int NUM_LINES   = DEF_NUM_LINES;
    localparam int LINE_LEN    = DEF_LINE_LEN;
    localparam int PTR_W       = $clog2(LINE_LEN);
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int TAIL_CYCLES = 64;
    localparam int LIMIT       = 500000;

    // Spread factor register map
    typedef enum logic [CFG_IDX_W-1:0] {
        SPREAD_F0 = 2'd0,
        SPREAD_F1 = 2'd1,
        SPREAD_F2 = 2'd2,
        SPREAD_F3 = 2'd3
    } t_spread_reg;

    // Tracks the delay lines and predicts each output sum
    class t_reverb_tap_tracker;
        bit signed [SAMPLE_W-1:0] line_mem [NUM_LINES][LINE_LEN];
        bit [PTR_W-1:0]           wr_ptr;
        bit signed [SAMPLE_W-1:0] spread_f [NUM_REGS];
        logic signed [OUT_W-1:0]  expected_out [$];
        int                       errors;

        function void set_spread(int idx, logic [SAMPLE_W-1:0] val);
            spread_f[idx] = val;
        endfunction

        // Accepted request: read every tap, then update all lines
        function void take_sample(logic signed [SAMPLE_W-1:0] smp,
                                  logic [DELAY_W-1:0] base,
                                  logic signed [DELAY_W-1:0] spread,
                                  logic signed [SAMPLE_W-1:0] gain);
            longint tap [NUM_LINES];
            longint f, d, tn, frac, a, b, idx, sum, num, den, fb, w;
            sum = 0;
            for (int j = 0; j < NUM_LINES; j++) begin
                f = 0;
                if (j < NUM_REGS) begin
                    f = spread_f[j];
                end
                d = longint'(base) + ((longint'(spread) * f) >>> 12);
                if (d < 256) begin
                    d = 256;
                end else if (d > longint'(LINE_LEN - 2) * 256) begin
                    d = longint'(LINE_LEN - 2) * 256;
                end
                tn   = (d + 255) >>> 8;
                frac = tn * 256 - d;
                idx  = (longint'(wr_ptr) + LINE_LEN - tn) % LINE_LEN;
                a    = line_mem[j][idx];
                b    = line_mem[j][(idx + 1) % LINE_LEN];
                tap[j] = a + ((frac * (b - a)) >>> 8);
                sum += tap[j];
            end

            // Householder term, floor division on the unsaturated sum
            num = -2 * longint'(gain) * sum;
            den = longint'(NUM_LINES) * 32768;
            fb  = num / den;
            if (num % den != 0 && num < 0) begin
                fb--;
            end

            for (int j = 0; j < NUM_LINES; j++) begin
                w = longint'(smp) + ((longint'(gain) * tap[j]) >>> 15) + fb;
                if (w < -32768) begin
                    w = -32768;
                end else if (w > 32767) begin
                    w = 32767;
                end
                line_mem[j][wr_ptr] = w[SAMPLE_W-1:0];
            end
            wr_ptr = PTR_W'((wr_ptr + 1) % LINE_LEN);

            if (sum < -131072) begin
                sum = -131072;
            end else if (sum > 131071) begin
                sum = 131071;
            end
            expected_out.push_back(sum[OUT_W-1:0]);
        endfunction

        // Accepted result: compare with the oldest prediction
        function void check_output(logic signed [OUT_W-1:0] got);
            logic signed [OUT_W-1:0] want;
            if (expected_out.size() == 0) begin
                errors++;
                $display("%0t: sample_out %0d with no request pending", $time, got);
            end else begin
                want = expected_out.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: sample_out mismatch expected %0d actual %0d",
                             $time, want, got);
                end
            end
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic signed [SAMPLE_W-1:0]   i_sample_in = '0;
    logic [DELAY_W-1:0]           i_base_delay = '0;
    logic signed [DELAY_W-1:0]    i_delay_spread = '0;
    logic signed [SAMPLE_W-1:0]   i_feedback_gain = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic signed [OUT_W-1:0]      o_sample_out;
    logic                         i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [SAMPLE_W-1:0]          i_cfg_data = '0;

    t_reverb_tap_tracker tracker = new();
    bit                  idle_on = 1'b1;
    int                  cycle_count = 0;

    feedback_delay_network_reverb_core #(
        .NUM_LINES(NUM_LINES),
        .LINE_LEN (LINE_LEN)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_in    (i_sample_in),
        .i_base_delay   (i_base_delay),
        .i_delay_spread (i_delay_spread),
        .i_feedback_gain(i_feedback_gain),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_out   (o_sample_out),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time,
                     tracker.expected_out.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Handshake monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                tracker.take_sample(i_sample_in, i_base_delay, i_delay_spread,
                                    i_feedback_gain);
            end
            if (o_out_valid && i_out_ready) begin
                tracker.check_output(o_sample_out);
            end
        end
    end

    // Receiver: random stall bursts while idling is on
    initial begin
        @(posedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    // One request, held until accepted, with an optional gap in front
    task automatic send_request(input logic signed [SAMPLE_W-1:0] smp,
                                input logic [DELAY_W-1:0] base,
                                input logic signed [DELAY_W-1:0] spread,
                                input logic signed [SAMPLE_W-1:0] gain);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_sample_in     <= smp;
        i_base_delay    <= base;
        i_delay_spread  <= spread;
        i_feedback_gain <= gain;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_spread(input t_spread_reg idx, input logic [SAMPLE_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        tracker.set_spread(idx, val);
        @(posedge i_clk);
    endtask

    // One edge first so the last accepted request is already noted
    task automatic wait_drained();
        @(posedge i_clk);
        while (tracker.expected_out.size() != 0) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        logic signed [SAMPLE_W-1:0] smp, gain;
        logic [DELAY_W-1:0]         base;
        logic signed [DELAY_W-1:0]  spread;
        logic [SAMPLE_W-1:0]        f;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: factors 1.0, -1.0, 2.0, 0.5
        write_spread(SPREAD_F0, 16'sd4096);
        write_spread(SPREAD_F1, -16'sd4096);
        write_spread(SPREAD_F2, 16'sd8192);
        write_spread(SPREAD_F3, 16'sd2048);
        i_cfg_we <= 1'b0;

        // one-sample taps, then positive saturation of the stored values
        send_request(16'sh7FFF, 20'd256, 20'sd0, 16'sd0);
        send_request(16'sh8000, 20'd256, 20'sd0, 16'sh7FFF);
        send_request(16'sh7FFF, 20'd256, 20'sd0, 16'sh7FFF);
        send_request(16'sh7FFF, 20'd256, 20'sd0, 16'sh7FFF);
        // half-sample interpolation, most negative gain
        send_request(16'sh8000, 20'd384, 20'sd0, 16'sh8000);
        // delay below one sample and above the upper clamp
        send_request(16'sd1000, 20'd0, 20'sd0, 16'sd16384);
        send_request(-16'sd1, 20'hFFFFF, 20'sd0, -16'sd1);
        // longest tap, and the largest fraction
        send_request(16'sd0, 20'(4094 * 256), 20'sd0, 16'sh7FFF);
        send_request(16'sd12345, 20'(4093 * 256 + 1), 20'sd0, 16'sh8000);
        // spread extremes push lines to opposite clamps
        send_request(-16'sd20000, 20'd512, 20'sh80000, 16'sd20000);
        send_request(16'sd20000, 20'd512, 20'sh7FFFF, -16'sd20000);
        send_request(16'sd0, 20'd1000, -20'sd300, 16'sd30000);
        send_request(16'sd5000, 20'd640, 20'sd256, -16'sd16384);
        send_request(-16'sd5000, 20'd700, 20'sd255, 16'sd16383);
        send_request(16'sh7FFF, 20'hFFFFF, 20'sh80000, 16'sh8000);
        send_request(16'sh8000, 20'd0, 20'sh7FFFF, 16'sh7FFF);
        send_request(16'sd0, 20'd257, 20'sd0, 16'sd0);
        send_request(16'sd1, 20'd511, 20'sd1, 16'sd1);

        // Random phases, each with its own spread factor setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            i_in_valid <= 1'b0;
            wait_drained();
            idle_on = (ph != 3) && (ph != NUM_PHASES - 1);
            for (int r = 0; r < NUM_REGS; r++) begin
                case (ph)
                    0: f = '0;
                    1: f = r[0] ? 16'h8000 : 16'h7FFF;
                    2: f = 16'(4096 + 819 * r);
                    4: f = (r == 0) ? 16'h8000 : (r == 1) ? 16'h7FFF :
                           (r == 2) ? 16'hFFFF : 16'h0001;
                    5: f = SAMPLE_W'($urandom);
                    default: f = 16'($urandom_range(0, 16384) - 8192);
                endcase
                write_spread(t_spread_reg'(r), f);
            end
            i_cfg_we <= 1'b0;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                smp = SAMPLE_W'($urandom);
                if ($urandom_range(0, 9) == 0) begin
                    smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                end
                case ($urandom_range(0, 9))
                    0: gain = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    1, 2: gain = SAMPLE_W'($urandom);
                    default: gain = 16'($urandom_range(0, 58000) - 29000);
                endcase
                // mostly short delays so taps land on recently written samples
                case ($urandom_range(0, 9))
                    0, 1: base = DELAY_W'($urandom);
                    2: base = DELAY_W'($urandom_range(4080 * 256, 4095 * 256));
                    default: base = DELAY_W'($urandom_range(0, 48 * 256));
                endcase
                case ($urandom_range(0, 9))
                    0, 1: spread = '0;
                    2, 3, 4: spread = DELAY_W'($urandom);
                    default: spread = 20'($urandom_range(0, 4096) - 2048);
                endcase
                send_request(smp, base, spread, gain);
            end
        end
        i_in_valid <= 1'b0;

        // Drain, then make sure nothing extra shows up
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.expected_out.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: feedback_delay_network_reverb_core.f
hdl/fdnr_pkg.sv
hdl/fdnr_fb_unit.sv
hdl/feedback_delay_network_reverb_core.sv
tb/feedback_delay_network_reverb_core_tb.sv
